### hw/rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared constants, types and character helpers for the binary-to-ASCII
// formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int DEC_DIGITS   = 20;
   localparam int HEX_DIGITS   = (VALUE_WIDTH + 3) / 4;
   localparam int STORE_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int IDX_W        = $clog2(STORE_DIGITS);
   localparam int BIT_W        = $clog2(VALUE_WIDTH);

   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_X       = 8'h78;
   localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;
   localparam logic [3:0] NIB_NINE      = 4'd9;

   localparam logic FUNC_DEC = 1'b0;
   localparam logic FUNC_HEX = 1'b1;

   // one character handed to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] code;
      logic       last;
   } emit_type;

   typedef logic [DEC_DIGITS-1:0][3:0]   dec_digits_type;
   typedef logic [STORE_DIGITS-1:0][3:0] store_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ext;
      ext = {4'b0000, nib};
      return (nib > NIB_NINE) ? (ext + HEX_ALPHA_OFS) : (ext + ASCII_ZERO);
   endfunction

   function automatic logic [7:0] dec_char(input logic [3:0] nib);
      return {4'b0000, nib} + ASCII_ZERO;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bta_dabble_step.sv
// ----------------------------------------------------------------------------
// bta_dabble_step
// One double dabble step: add 3 to every BCD digit of 5 or more, then shift
// the whole BCD word left by one with the next value bit entering at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_dabble_step (
   input  var bta_pkg::dec_digits_type bcd_cur,
   input  wire                         bit_in,
   output bta_pkg::dec_digits_type     bcd_next
);

   bta_pkg::dec_digits_type adj;

   always_comb begin
      for (int d = 0; d < bta_pkg::DEC_DIGITS; d++) begin
         adj[d] = (bcd_cur[d] >= 4'd5) ? (bcd_cur[d] + 4'd3) : bcd_cur[d];
      end
   end

   // top carry falls off the end
   assign bcd_next = (bta_pkg::DEC_DIGITS*4)'({adj, bit_in});

endmodule

`default_nettype wire

### hw/rtl/bta_char_out.sv
// ----------------------------------------------------------------------------
// bta_char_out
// Output register for the character channel; takes a new character whenever
// the held one is gone or is being transferred in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_char_out (
   input  wire                clock,
   input  wire                reset,
   input  var bta_pkg::emit_type emit,
   output logic               slot_free,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_last
);

   logic       valid_ff, valid_in;
   logic [7:0] code_ff;
   logic       last_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (emit.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         code_ff <= emit.code;
         last_ff <= emit.last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = code_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

### hw/rtl/binary_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_digits
// Formats an unsigned value as ASCII characters: decimal with no leading zeros
// by double dabble, or hex with a 0x prefix, one character per transfer.
// ----------------------------------------------------------------------------
// Decimal: the value is loaded, shifted and adjusted on the dabble unit once per
//   value bit (VALUE_WIDTH, 64), then each of the DEC_DIGITS (20) digit positions
//   is either skipped as a leading zero or sent as a character.
// Hex: the value is loaded, then the 0x prefix and HEX_DIGITS (16) digits are sent.
// Not ready again until the last character sits in the output register.
// Synchronous reset clears the sequencer and output valid; the digit store is not cleared.
`default_nettype none

module binary_to_ascii_digits (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_func,
   input  wire  [63:0] req_value,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_PFX0 = 5'b00100,
      ST_PFX1 = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   bta_pkg::store_type              store_ff, store_in;
   logic [bta_pkg::VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [bta_pkg::BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [bta_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                            started_ff, started_in;
   logic                            mode_ff, mode_in;

   bta_pkg::dec_digits_type         dabble_out;
   logic [bta_pkg::HEX_DIGITS*4-1:0] hex_src;
   logic [3:0]                      digit;
   logic                            slot_free;
   bta_pkg::emit_type               emit;

   bta_dabble_step u_dabble (
      .bcd_cur  (store_ff[bta_pkg::DEC_DIGITS-1:0]),
      .bit_in   (shift_ff[bta_pkg::VALUE_WIDTH-1]),
      .bcd_next (dabble_out)
   );

   bta_char_out u_char_out (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .slot_free     (slot_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   assign hex_src   = (bta_pkg::HEX_DIGITS*4)'(req_value[bta_pkg::VALUE_WIDTH-1:0]);
   assign digit     = store_ff[idx_ff];
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      store_in   = store_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      mode_in    = mode_ff;
      emit       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_func;
               if (req_func == bta_pkg::FUNC_HEX) begin
                  store_in = '0;
                  store_in[bta_pkg::HEX_DIGITS-1:0] = hex_src;
                  idx_in   = bta_pkg::IDX_W'(bta_pkg::HEX_DIGITS - 1);
                  state_in = ST_PFX0;
               end else begin
                  store_in   = '0;
                  shift_in   = req_value[bta_pkg::VALUE_WIDTH-1:0];
                  bit_cnt_in = bta_pkg::BIT_W'(bta_pkg::VALUE_WIDTH - 1);
                  state_in   = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            store_in[bta_pkg::DEC_DIGITS-1:0] = dabble_out;
            shift_in = {shift_ff[bta_pkg::VALUE_WIDTH-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               idx_in     = bta_pkg::IDX_W'(bta_pkg::DEC_DIGITS - 1);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_PFX0: begin
            if (slot_free) begin
               emit     = '{valid: 1'b1, code: bta_pkg::ASCII_ZERO, last: 1'b0};
               state_in = ST_PFX1;
            end
         end
         ST_PFX1: begin
            if (slot_free) begin
               emit       = '{valid: 1'b1, code: bta_pkg::ASCII_X, last: 1'b0};
               started_in = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // leading zeros are skipped one digit a cycle, digit 0 always goes out
            if (!started_ff && digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else if (slot_free) begin
               emit.valid = 1'b1;
               emit.code  = (mode_ff == bta_pkg::FUNC_HEX) ? bta_pkg::hex_char(digit)
                                                          : bta_pkg::dec_char(digit);
               emit.last  = (idx_ff == '0);
               started_in = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         idx_ff     <= '0;
         started_ff <= 1'b0;
         mode_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         idx_ff     <= idx_in;
         started_ff <= started_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire
